@@ src/ssdp_hp_pkg.sv @@
// ssdp_hp_pkg: shared types, codes and string constants of the ssdp header parser
// used by the front, queue, back and top level; no dependencies
package ssdp_hp_pkg;

  // widest line position, set by the largest supported line buffer (2048 bytes)
  localparam int PosW = 11;

  // operations passed from the front end to the line engine
  typedef enum logic [1:0] {
    OP_STORE,
    OP_LINE,
    OP_END
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [PosW-1:0] pos;      // store address, or length of the line to parse
    logic [7:0]     data;
    logic           end_pkt;   // a packet end result follows the line results
    logic [1:0]     method;
    logic [1:0]     status;
  } op_t;

  // result kinds
  localparam logic [2:0] KIND_ST  = 3'd0;
  localparam logic [2:0] KIND_NTS = 3'd1;
  localparam logic [2:0] KIND_USN = 3'd2;
  localparam logic [2:0] KIND_LOC = 3'd3;
  localparam logic [2:0] KIND_AGE = 3'd4;
  localparam logic [2:0] KIND_END = 3'd5;

  // methods
  localparam logic [1:0] METH_NONE = 2'd0;

  // packet status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_START = 2'd1;
  localparam logic [1:0] STAT_ZERO      = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // start lines, character 0 in the top byte of the used part
  localparam logic [167:0] STR_MSEARCH = "M-SEARCH * HTTP/1.1\r\n";
  localparam logic [167:0] STR_NOTIFY  = "NOTIFY * HTTP/1.1\r\n";
  localparam logic [167:0] STR_RESP    = "HTTP/1.1 200 OK\r\n";
  localparam int LEN_MSEARCH = 21;
  localparam int LEN_NOTIFY  = 19;
  localparam int LEN_RESP    = 17;

  // header names, lower case
  localparam int NumFields = 6;
  localparam logic [167:0] STR_ST    = "st";
  localparam logic [167:0] STR_NT    = "nt";
  localparam logic [167:0] STR_NTS   = "nts";
  localparam logic [167:0] STR_USN   = "usn";
  localparam logic [167:0] STR_LOC   = "location";
  localparam logic [167:0] STR_CACHE = "cache-control";
  localparam logic [167:0] STR_MAXAGE = "max-age=";
  localparam int MaxAgeLen = 8;

  // byte k of a right-aligned string of length len
  function automatic logic [7:0] str_at(input logic [167:0] s, input int len, input int k);
    logic [7:0] r;
    r = 8'h00;
    if (k >= 0 && k < len) r = s[(len-1-k)*8 +: 8];
    return r;
  endfunction

  function automatic int start_len(input int m);
    int r;
    unique case (m)
      0:       r = LEN_MSEARCH;
      1:       r = LEN_NOTIFY;
      default: r = LEN_RESP;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] start_char(input int m, input int k);
    logic [7:0] r;
    unique case (m)
      0:       r = str_at(STR_MSEARCH, LEN_MSEARCH, k);
      1:       r = str_at(STR_NOTIFY, LEN_NOTIFY, k);
      default: r = str_at(STR_RESP, LEN_RESP, k);
    endcase
    return r;
  endfunction

  function automatic int hdr_name_len(input int f);
    int r;
    unique case (f)
      0:       r = 2;
      1:       r = 2;
      2:       r = 3;
      3:       r = 3;
      4:       r = 8;
      default: r = 13;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] field_char(input int f, input int k);
    logic [7:0] r;
    unique case (f)
      0:       r = str_at(STR_ST, 2, k);
      1:       r = str_at(STR_NT, 2, k);
      2:       r = str_at(STR_NTS, 3, k);
      3:       r = str_at(STR_USN, 3, k);
      4:       r = str_at(STR_LOC, 8, k);
      default: r = str_at(STR_CACHE, 13, k);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  // bytes that trimming removes
  function automatic logic is_junk(input logic [7:0] b);
    return b < 8'h21 || b > 8'h7E;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

@@ src/ssdp_header_parser_core.sv @@
// ssdp_header_parser_core: top level of the ssdp header parser, holds the max-age register
// depends on ssdp_hp_pkg, ssdp_hp_front, ssdp_hp_queue and ssdp_hp_back
//
// Bytes of a datagram enter one per transfer on the input channel. The front end takes
// a byte whenever the two-entry operation queue has room. A byte that only extends a
// header line costs the line engine a line buffer write. The byte that ends a line
// (CR LF) makes the engine scan the buffered line through its single read port, then
// send out the value bytes or a max-age result, and any packet end result; the front
// end keeps collecting behind it until the queue fills. Results leave through a
// registered output stage.
module ssdp_header_parser_core #(
  parameter int VALUE_LIMIT = 63,
  parameter int LINE_LEN    = 256,
  parameter int PACKET_LEN  = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [7:0]         value_byte_o,
  output logic signed [31:0] max_age_o,
  output logic [1:0]         method_o,
  output logic [1:0]         status_o,
  output logic               last_in_run_o
);
  import ssdp_hp_pkg::*;

  logic [15:0] max_age_def_q;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  op_t         fq_op, qb_op;
  logic [31:0] age;

  // default max-age register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_age_def_q <= 16'd10;
    else if (cfg_valid_i) max_age_def_q <= cfg_data_i;
  end

  ssdp_hp_front #(.LINE_LEN(LINE_LEN), .PACKET_LEN(PACKET_LEN)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .last_byte_i,
    .op_valid_o(fq_valid), .op_ready_i(fq_ready), .op_o(fq_op)
  );

  ssdp_hp_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fq_valid), .push_ready_o(fq_ready), .push_op_i(fq_op),
    .pop_valid_o(qb_valid), .pop_ready_i(qb_ready), .pop_op_o(qb_op)
  );

  ssdp_hp_back #(.LINE_LEN(LINE_LEN), .VALUE_LIMIT(VALUE_LIMIT)) u_back (
    .clk_i, .rst_ni, .default_max_age_i(max_age_def_q),
    .op_valid_i(qb_valid), .op_ready_o(qb_ready), .op_i(qb_op),
    .out_valid_o, .out_ready_i, .kind_o, .value_byte_o, .max_age_o(age),
    .method_o, .status_o, .last_in_run_o
  );

  assign max_age_o = signed'(age);

endmodule

@@ src/ssdp_hp_front.sv @@
// ssdp_hp_front: takes datagram bytes, matches the start line, tracks line boundaries
// and issues store, line and packet end operations; uses ssdp_hp_pkg
module ssdp_hp_front #(
  parameter int LINE_LEN   = 256,
  parameter int PACKET_LEN = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               op_valid_o,
  input  logic               op_ready_i,
  output ssdp_hp_pkg::op_t   op_o
);
  import ssdp_hp_pkg::*;

  localparam int LenW = $clog2(LINE_LEN + 1);
  localparam int CntW = $clog2(PACKET_LEN + 1);

  logic [LenW-1:0] line_len_q;
  logic            ovf_q, zero_q, cr_q;
  logic [4:0]      pos_q;
  logic [2:0]      cand_q;
  logic [1:0]      meth_q;
  logic [CntW-1:0] cnt_q;

  logic       accept, proc, zero_d, live, in_line, in_start, eol, just, has_op;
  logic [2:0] cand_n;
  logic [4:0] pos_n;
  logic [1:0] meth_n, stat;
  op_t        op;

  assign in_ready_o = op_ready_i;
  assign accept     = in_valid_i && op_ready_i;

  // classify the byte
  always_comb begin
    proc     = cnt_q < CntW'(PACKET_LEN);
    zero_d   = zero_q | (proc && data_byte_i == 8'h00);
    live     = proc && !zero_d;
    in_line  = live && meth_q != METH_NONE;
    in_start = live && meth_q == METH_NONE && cand_q != 3'b000;
    pos_n    = (pos_q != 5'd31) ? pos_q + 5'd1 : pos_q;
    cand_n   = cand_q;
    meth_n   = meth_q;
    just     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (int'(pos_q) >= start_len(k) || start_char(k, int'(pos_q)) != data_byte_i)
        cand_n[k] = 1'b0;
    end
    if (in_start) begin
      for (int k = 0; k < 3; k++) begin
        if (cand_n[k] && int'(pos_n) == start_len(k)) begin
          meth_n = 2'(k + 1);
          just   = 1'b1;
        end
      end
    end
    eol = in_line && data_byte_i == CHAR_LF && cr_q && line_len_q >= LenW'(2);
    if (zero_d) stat = STAT_ZERO;
    else if (meth_n == METH_NONE || just) stat = STAT_BAD_START;
    else stat = STAT_OK;
  end

  // build the operation for the line engine
  always_comb begin
    op.op      = OP_END;
    op.pos     = PosW'(line_len_q);
    op.data    = data_byte_i;
    op.end_pkt = last_byte_i;
    op.method  = (stat == STAT_OK) ? meth_n : METH_NONE;
    op.status  = stat;
    has_op     = 1'b0;
    if (eol && !ovf_q) begin
      op.op  = OP_LINE;
      op.pos = PosW'(line_len_q - LenW'(1));
      has_op = 1'b1;
    end else if (last_byte_i) begin
      op.op  = OP_END;
      has_op = 1'b1;
    end else if (in_line && !eol && line_len_q < LenW'(LINE_LEN)) begin
      op.op  = OP_STORE;
      has_op = 1'b1;
    end
  end

  assign op_o       = op;
  assign op_valid_o = in_valid_i && has_op;

  // packet and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
      ovf_q      <= 1'b0;
      zero_q     <= 1'b0;
      cr_q       <= 1'b0;
      pos_q      <= '0;
      cand_q     <= 3'b111;
      meth_q     <= METH_NONE;
      cnt_q      <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        line_len_q <= '0;
        ovf_q      <= 1'b0;
        zero_q     <= 1'b0;
        cr_q       <= 1'b0;
        pos_q      <= '0;
        cand_q     <= 3'b111;
        meth_q     <= METH_NONE;
        cnt_q      <= '0;
      end else begin
        if (proc) cnt_q <= cnt_q + CntW'(1);
        zero_q <= zero_d;
        if (in_start) begin
          cand_q <= cand_n;
          pos_q  <= pos_n;
          meth_q <= meth_n;
        end
        if (in_line) begin
          if (eol) begin
            line_len_q <= '0;
            ovf_q      <= 1'b0;
            cr_q       <= 1'b0;
          end else begin
            if (line_len_q < LenW'(LINE_LEN)) line_len_q <= line_len_q + LenW'(1);
            else ovf_q <= 1'b1;
            cr_q <= data_byte_i == CHAR_CR;
          end
        end
      end
    end
  end

endmodule

@@ src/ssdp_hp_queue.sv @@
// ssdp_hp_queue: two-entry queue of operations between front end and line engine
// uses ssdp_hp_pkg
module ssdp_hp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ssdp_hp_pkg::op_t push_op_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ssdp_hp_pkg::op_t pop_op_o
);
  import ssdp_hp_pkg::*;

  op_t        entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = fill_q != 2'd2;
  assign pop_valid_o  = fill_q != 2'd0;
  assign pop_op_o     = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_q] <= push_op_i;
  end

endmodule

@@ src/ssdp_hp_back.sv @@
// ssdp_hp_back: line engine; holds the line buffer, scans finished lines, and sends
// value bytes, max-age and packet end results; uses ssdp_hp_pkg
module ssdp_hp_back #(
  parameter int LINE_LEN    = 256,
  parameter int VALUE_LIMIT = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      default_max_age_i,
  input  logic             op_valid_i,
  output logic             op_ready_o,
  input  ssdp_hp_pkg::op_t op_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       value_byte_o,
  output logic [31:0]      max_age_o,
  output logic [1:0]       method_o,
  output logic [1:0]       status_o,
  output logic             last_in_run_o
);
  import ssdp_hp_pkg::*;

  localparam int PW = $clog2(LINE_LEN);
  localparam int CW = $clog2(VALUE_LIMIT + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_AGE, S_RUN, S_END} state_e;
  typedef enum logic [1:0] {N_WS, N_DIG, N_DONE} num_e;

  logic [7:0] mem [LINE_LEN];
  logic [7:0] rd_q;

  state_e state_q, state_d;
  logic [PW-1:0] len_q, len_d, rd_pos_q, rd_pos_d, ppos_q, ppos_d;
  logic [PW-1:0] va_q, va_d, vb_q, vb_d;
  logic dv_q, dv_d, pend_q, pend_d, end_q, end_d;
  logic [1:0] meth_q, meth_d, stat_q, stat_d;
  logic bad0_q, bad0_d, colon_q, colon_d, fa_q, fa_d, va_f_q, va_f_d;
  logic [3:0] fidx_q, fidx_d, vidx_q, vidx_d;
  logic [NumFields-1:0] run_q, run_d, fok_q, fok_d;
  logic mrun_q, mrun_d, mok_q, mok_d, neg_q, neg_d;
  num_e nst_q, nst_d;
  logic [31:0] acc_q, acc_d;
  logic [CW-1:0] left_q, left_d;
  logic out_v_q, out_v_d;
  logic [2:0] kind_q, kind_d;
  logic [7:0] vbyte_q, vbyte_d;
  logic [31:0] age_q, age_d;
  logic [1:0] om_q, om_d, os_q, os_d;
  logic olast_q, olast_d;

  logic can_emit, store_wr, r, line_ok;
  logic [7:0] b;
  logic [3:0] k;
  logic [35:0] prod;
  logic [PW-1:0] span;
  logic [31:0] age_val;

  assign can_emit   = !out_v_q || out_ready_i;
  assign op_ready_o = state_q == S_IDLE;
  assign store_wr   = state_q == S_IDLE && op_valid_i && op_i.op == OP_STORE;

  assign out_valid_o   = out_v_q;
  assign kind_o        = kind_q;
  assign value_byte_o  = vbyte_q;
  assign max_age_o     = age_q;
  assign method_o      = om_q;
  assign status_o      = os_q;
  assign last_in_run_o = olast_q;

  // line buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (store_wr) mem[op_i.pos[PW-1:0]] <= op_i.data;
    rd_q <= mem[rd_pos_q];
  end

  // next state and scan logic
  always_comb begin
    state_d = state_q;  len_d = len_q;  rd_pos_d = rd_pos_q;  ppos_d = ppos_q;
    va_d = va_q;  vb_d = vb_q;  dv_d = 1'b0;  pend_d = pend_q;  end_d = end_q;
    meth_d = meth_q;  stat_d = stat_q;  bad0_d = bad0_q;  colon_d = colon_q;
    fa_d = fa_q;  va_f_d = va_f_q;  fidx_d = fidx_q;  vidx_d = vidx_q;
    run_d = run_q;  fok_d = fok_q;  mrun_d = mrun_q;  mok_d = mok_q;  neg_d = neg_q;
    nst_d = nst_q;  acc_d = acc_q;  left_d = left_q;
    out_v_d = out_v_q && !out_ready_i;
    kind_d = kind_q;  vbyte_d = vbyte_q;  age_d = age_q;  om_d = om_q;  os_d = os_q;
    olast_d = olast_q;
    b = rd_q;  k = 4'd0;  r = 1'b0;  prod = '0;
    span = vb_q - va_q;
    line_ok = !bad0_q && colon_q && fa_q && va_f_q;
    if (neg_q) age_val = 32'd0 - acc_q;
    else if (acc_q > 32'h7FFF_FFFF) age_val = 32'h7FFF_FFFF;
    else age_val = acc_q;
    if (age_val == 32'd0) age_val = {16'd0, default_max_age_i};

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          end_d  = op_i.end_pkt;
          meth_d = op_i.method;
          stat_d = op_i.status;
          unique case (op_i.op)
            OP_STORE: state_d = S_IDLE;
            OP_LINE: begin
              state_d = S_SCAN;
              len_d = op_i.pos[PW-1:0];
              rd_pos_d = '0;
              bad0_d = 1'b0;  colon_d = 1'b0;  fa_d = 1'b0;  va_f_d = 1'b0;
              fidx_d = '0;  vidx_d = '0;  run_d = '0;  fok_d = '0;
              mrun_d = 1'b0;  mok_d = 1'b0;  neg_d = 1'b0;  nst_d = N_WS;  acc_d = '0;
            end
            default: state_d = S_END;
          endcase
        end
      end

      S_SCAN: begin
        // issue reads back to back
        if (rd_pos_q < len_q) begin
          rd_pos_d = rd_pos_q + PW'(1);
          dv_d = 1'b1;
          ppos_d = rd_pos_q;
        end
        if (dv_q) begin
          if (!colon_q && ppos_q != '0 && b == CHAR_COLON) begin
            colon_d = 1'b1;
          end else if (!colon_q) begin
            // header name bytes
            if (ppos_q == '0 && b == CHAR_COLON) bad0_d = 1'b1;
            if (fa_q || !is_junk(b)) begin
              k = fa_q ? fidx_q : 4'd0;
              for (int s = 0; s < NumFields; s++) begin
                r = (fa_q ? run_q[s] : 1'b1) && int'(k) < hdr_name_len(s)
                    && to_lower(b) == field_char(s, int'(k));
                run_d[s] = r;
                if (!is_junk(b)) fok_d[s] = r && int'(k) + 1 == hdr_name_len(s);
              end
              fa_d = 1'b1;
              fidx_d = (k == 4'd15) ? k : k + 4'd1;
            end
          end else begin
            // value bytes
            if (va_f_q || !is_junk(b)) begin
              if (!va_f_q) va_d = ppos_q;
              va_f_d = 1'b1;
              k = va_f_q ? vidx_q : 4'd0;
              if (int'(k) < MaxAgeLen) begin
                r = (k == 4'd0 || mrun_q) && to_lower(b) == str_at(STR_MAXAGE, MaxAgeLen, int'(k));
                mrun_d = r;
                if (int'(k) == MaxAgeLen - 1) mok_d = r;
              end else if (mok_q) begin
                prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {28'd0, b - 8'h30};
                unique case (nst_q)
                  N_WS: begin
                    if (is_ws(b)) nst_d = N_WS;
                    else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                      neg_d = b == CHAR_MINUS;
                      nst_d = N_DIG;
                    end else if (is_digit(b)) begin
                      acc_d = {24'd0, b - 8'h30};
                      nst_d = N_DIG;
                    end else nst_d = N_DONE;
                  end
                  N_DIG: begin
                    if (is_digit(b)) acc_d = (prod > 36'h0_8000_0000) ? 32'h8000_0000 : prod[31:0];
                    else nst_d = N_DONE;
                  end
                  default: nst_d = N_DONE;
                endcase
              end
              vidx_d = (int'(k) == MaxAgeLen) ? k : k + 4'd1;
            end
            if (!is_junk(b)) vb_d = ppos_q + PW'(1);
          end
          if (ppos_q == len_q - PW'(1)) state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        pend_d = 1'b0;
        rd_pos_d = va_q;
        if (32'(span) > 32'(VALUE_LIMIT)) left_d = CW'(VALUE_LIMIT);
        else left_d = CW'(span);
        state_d = end_q ? S_END : S_IDLE;
        if (line_ok) begin
          priority if (fok_q[0] || fok_q[1]) begin kind_d = KIND_ST;  state_d = S_RUN; end
          else if (fok_q[2]) begin kind_d = KIND_NTS; state_d = S_RUN; end
          else if (fok_q[3]) begin kind_d = KIND_USN; state_d = S_RUN; end
          else if (fok_q[4]) begin kind_d = KIND_LOC; state_d = S_RUN; end
          else if (fok_q[5] && mok_q) state_d = S_AGE;
        end
        // hold the output kind while an earlier result still waits
        if (out_v_q) kind_d = kind_q;
      end

      S_AGE: begin
        if (can_emit) begin
          out_v_d = 1'b1;  kind_d = KIND_AGE;  vbyte_d = '0;  age_d = age_val;
          om_d = METH_NONE;  os_d = STAT_OK;  olast_d = !end_q;
          state_d = end_q ? S_END : S_IDLE;
        end
      end

      S_RUN: begin
        if (!pend_q) pend_d = 1'b1;
        else if (can_emit) begin
          out_v_d = 1'b1;  vbyte_d = rd_q;  age_d = '0;
          om_d = METH_NONE;  os_d = STAT_OK;  olast_d = left_q == CW'(1) && !end_q;
          unique case (fok_q[0] || fok_q[1])
            1'b1: kind_d = KIND_ST;
            default: kind_d = fok_q[2] ? KIND_NTS : (fok_q[3] ? KIND_USN : KIND_LOC);
          endcase
          pend_d = 1'b0;
          rd_pos_d = rd_pos_q + PW'(1);
          left_d = left_q - CW'(1);
          if (left_q == CW'(1)) state_d = end_q ? S_END : S_IDLE;
        end
      end

      S_END: begin
        if (can_emit) begin
          out_v_d = 1'b1;  kind_d = KIND_END;  vbyte_d = '0;  age_d = '0;
          om_d = meth_q;  os_d = stat_q;  olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dv_q    <= 1'b0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= dv_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  // scan and result payload
  always_ff @(posedge clk_i) begin
    len_q <= len_d;  rd_pos_q <= rd_pos_d;  ppos_q <= ppos_d;  va_q <= va_d;  vb_q <= vb_d;
    end_q <= end_d;  meth_q <= meth_d;  stat_q <= stat_d;  bad0_q <= bad0_d;
    colon_q <= colon_d;  fa_q <= fa_d;  va_f_q <= va_f_d;  fidx_q <= fidx_d;
    vidx_q <= vidx_d;  run_q <= run_d;  fok_q <= fok_d;  mrun_q <= mrun_d;  mok_q <= mok_d;
    neg_q <= neg_d;  nst_q <= nst_d;  acc_q <= acc_d;  left_q <= left_d;
    kind_q <= kind_d;  vbyte_q <= vbyte_d;  age_q <= age_d;  om_q <= om_d;  os_q <= os_d;
    olast_q <= olast_d;
  end

endmodule

@@ sim/ssdp_hp_checker.sv @@
// ssdp_hp_checker: watches the config, byte and result channels of the ssdp header parser,
// predicts the results of every accepted byte and compares them in order
// depends on nothing but the channel signals it is connected to
module ssdp_hp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  value_byte_i,
  input  logic [31:0] max_age_i,
  input  logic [1:0]  method_i,
  input  logic [1:0]  status_i,
  input  logic        last_in_run_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineMax   = 256;
  localparam int PacketMax = 2048;
  localparam int ValueMax  = 63;

  localparam logic [2:0] K_ST  = 3'd0;
  localparam logic [2:0] K_NTS = 3'd1;
  localparam logic [2:0] K_USN = 3'd2;
  localparam logic [2:0] K_LOC = 3'd3;
  localparam logic [2:0] K_AGE = 3'd4;
  localparam logic [2:0] K_END = 3'd5;

  localparam logic [1:0] S_OK   = 2'd0;
  localparam logic [1:0] S_BAD  = 2'd1;
  localparam logic [1:0] S_ZERO = 2'd2;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  value_byte;
    logic [31:0] max_age;
    logic [1:0]  method;
    logic [1:0]  status;
    logic        last_in_run;
  } ssdp_result_t;

  ssdp_result_t result_q[$];

  string start_txt[3] = '{"M-SEARCH * HTTP/1.1\r\n", "NOTIFY * HTTP/1.1\r\n",
                          "HTTP/1.1 200 OK\r\n"};

  // parser state, mirrored from the block
  logic [7:0]  line_mem[LineMax];
  int          line_cnt;
  bit          line_long;
  int          start_pos;
  bit [2:0]    cand;
  int          found_method;
  int          pkt_bytes;
  bit          zero_hit;
  bit          after_cr;
  logic [15:0] dflt_age;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = result_q.size();

  function automatic logic [7:0] lc(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic bit trim_byte(logic [7:0] b);
    return b < 8'h21 || b > 8'h7E;
  endfunction

  function automatic bit name_eq(int pos, int len, string s);
    if (len != s.len()) return 0;
    for (int k = 0; k < len; k++)
      if (lc(line_mem[pos + k]) != lc(s[k])) return 0;
    return 1;
  endfunction

  task automatic push_result(logic [2:0] kind, logic [7:0] vb, logic [31:0] age,
                             logic [1:0] meth, logic [1:0] st);
    ssdp_result_t r;
    r.kind = kind; r.value_byte = vb; r.max_age = age;
    r.method = meth; r.status = st; r.last_in_run = 0;
    result_q.push_back(r);
  endtask

  // atoi with saturation, never past the line end
  function automatic logic [31:0] age_number(int p, int e);
    bit     neg;
    longint acc;
    neg = 0;
    acc = 0;
    while (p < e && (line_mem[p] == 8'h20 || (line_mem[p] >= 8'h09 && line_mem[p] <= 8'h0D)))
      p++;
    if (p < e && (line_mem[p] == "+" || line_mem[p] == "-")) begin
      neg = line_mem[p] == "-";
      p++;
    end
    while (p < e && line_mem[p] >= "0" && line_mem[p] <= "9") begin
      acc = acc * 10 + (line_mem[p] - "0");
      if (acc > 64'd2147483648) acc = 64'd2147483648;
      p++;
    end
    if (neg) return 32'(-acc);
    if (acc > 64'd2147483647) acc = 64'd2147483647;
    return 32'(acc);
  endfunction

  // parse one complete header line (CR still in the buffer)
  task automatic header_line();
    int len, c, fa, fb, va, vb, n;
    logic [2:0]  kind;
    logic [31:0] age;
    len = line_cnt - 1;
    if (len == 0 || line_mem[0] == ":") return;
    for (c = 1; c < len; c++)
      if (line_mem[c] == ":") break;
    if (c >= len || c == len - 1) return;
    fa = 0; fb = c;
    while (fa < fb && trim_byte(line_mem[fa])) fa++;
    while (fb > fa && trim_byte(line_mem[fb - 1])) fb--;
    if (fa == fb) return;
    va = c + 1; vb = len;
    while (va < vb && trim_byte(line_mem[va])) va++;
    while (vb > va && trim_byte(line_mem[vb - 1])) vb--;
    if (va == vb) return;
    if (name_eq(fa, fb - fa, "st") || name_eq(fa, fb - fa, "nt")) kind = K_ST;
    else if (name_eq(fa, fb - fa, "nts")) kind = K_NTS;
    else if (name_eq(fa, fb - fa, "usn")) kind = K_USN;
    else if (name_eq(fa, fb - fa, "location")) kind = K_LOC;
    else if (name_eq(fa, fb - fa, "cache-control")) begin
      if (vb - va < 8 || !name_eq(va, 8, "max-age=")) return;
      age = age_number(va + 8, vb);
      if (age == 0) age = {16'd0, dflt_age};
      push_result(K_AGE, 8'd0, age, 2'd0, S_OK);
      return;
    end else return;
    n = (vb - va > ValueMax) ? ValueMax : vb - va;
    for (int k = 0; k < n; k++) push_result(kind, line_mem[va + k], 32'd0, 2'd0, S_OK);
  endtask

  task automatic clear_packet();
    line_cnt = 0; line_long = 0; start_pos = 0; cand = 3'b111;
    found_method = 0; pkt_bytes = 0; zero_hit = 0; after_cr = 0;
  endtask

  // expected results of one accepted byte
  task automatic predict_byte(logic [7:0] b, logic last);
    int         q0;
    bit         just_matched;
    logic [1:0] st;
    q0 = result_q.size();
    just_matched = 0;
    if (pkt_bytes < PacketMax) begin
      pkt_bytes++;
      if (b == 8'h00) zero_hit = 1;
      if (!zero_hit) begin
        if (found_method != 0) begin
          if (b == 8'h0A && after_cr && line_cnt >= 2) begin
            if (!line_long) header_line();
            line_cnt = 0; line_long = 0; after_cr = 0;
          end else begin
            if (line_cnt < LineMax) begin
              line_mem[line_cnt] = b;
              line_cnt++;
            end else line_long = 1;
            after_cr = b == 8'h0D;
          end
        end else if (cand != 0) begin
          for (int k = 0; k < 3; k++)
            if (cand[k] && (start_pos >= start_txt[k].len() || start_txt[k][start_pos] != b))
              cand[k] = 0;
          if (start_pos < 31) start_pos++;
          for (int k = 0; k < 3; k++)
            if (cand[k] && start_pos == start_txt[k].len()) begin
              found_method = k + 1;
              just_matched = 1;
            end
        end
      end
    end
    if (last) begin
      if (zero_hit) st = S_ZERO;
      else if (found_method == 0 || just_matched) st = S_BAD;
      else st = S_OK;
      push_result(K_END, 8'd0, 32'd0, st == S_OK ? 2'(found_method) : 2'd0, st);
      clear_packet();
    end
    if (result_q.size() > q0) result_q[result_q.size() - 1].last_in_run = 1;
  endtask

  task automatic mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    errors++;
  endtask

  // config, byte and result transfers, prediction before comparison
  always @(posedge clk_i or negedge rst_ni) begin
    ssdp_result_t e;
    if (!rst_ni) begin
      result_q.delete();
      clear_packet();
      dflt_age = 16'd10;
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) dflt_age = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_byte(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, kind %0d value %0h", $time, kind_i, value_byte_i);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (kind_i !== e.kind) mismatch("kind", 32'(e.kind), 32'(kind_i));
          if (value_byte_i !== e.value_byte)
            mismatch("value_byte", 32'(e.value_byte), 32'(value_byte_i));
          if (max_age_i !== e.max_age) mismatch("max_age", e.max_age, max_age_i);
          if (method_i !== e.method) mismatch("method", 32'(e.method), 32'(method_i));
          if (status_i !== e.status) mismatch("status", 32'(e.status), 32'(status_i));
          if (last_in_run_i !== e.last_in_run)
            mismatch("last_in_run", 32'(e.last_in_run), 32'(last_in_run_i));
        end
      end
    end
  end

endmodule

@@ sim/tb_ssdp_header_parser_core.sv @@
// tb_ssdp_header_parser_core: drives datagrams and config writes into the ssdp header parser
// depends on ssdp_header_parser_core and ssdp_hp_checker, which predicts and compares
module tb_ssdp_header_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam int DrainWait  = 600;
  localparam int RandBytes  = 420;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         kind;
  logic [7:0]         value_byte;
  logic signed [31:0] max_age;
  logic [1:0]         method;
  logic [1:0]         status;
  logic               last_in_run;
  int                 errors;
  int                 pending;

  logic [7:0] pkt[$];
  int         sent_bytes;
  bit         calm;
  int         out_hold;
  int         idle_cycles;

  ssdp_header_parser_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .data_byte_i(data_byte), .last_byte_i(last_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o(kind), .value_byte_o(value_byte), .max_age_o(max_age),
    .method_o(method), .status_o(status), .last_in_run_o(last_in_run)
  );

  ssdp_hp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .data_byte_i(data_byte), .last_byte_i(last_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .kind_i(kind), .value_byte_i(value_byte), .max_age_i(max_age),
    .method_i(method), .status_i(status), .last_in_run_i(last_in_run),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // random gap length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // quiet and busy stretches for both sides
  always @(posedge clk) if ($urandom_range(0, 399) == 0) calm <= ~calm;

  // result side back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_hold = gap_len();
      out_ready <= out_hold == 0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    in_valid <= 1'b0;
    pkt.delete();
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_age(logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  // letters flipped to random case
  task automatic add_name(string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      pkt.push_back(c);
    end
  endtask

  task automatic add_start(int m);
    case (m)
      0: add_str("M-SEARCH * HTTP/1.1\r\n");
      1: add_str("NOTIFY * HTTP/1.1\r\n");
      default: add_str("HTTP/1.1 200 OK\r\n");
    endcase
  endtask

  task automatic add_junk();
    repeat ($urandom_range(0, 2)) pkt.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
  endtask

  task automatic add_value(int n);
    for (int i = 0; i < n; i++)
      pkt.push_back($urandom_range(0, 15) == 0 ? 8'h20 : 8'($urandom_range(8'h21, 8'h7E)));
  endtask

  // one header line, well formed most of the time
  task automatic add_header();
    int sel, r;
    sel = $urandom_range(0, 11);
    if (sel == 10) begin
      // broken line: leading colon, no colon or empty value
      r = $urandom_range(0, 2);
      if (r == 0) add_str(":st: x");
      else if (r == 1) add_name("location");
      else add_name("usn:  ");
      add_str("\r\n");
      return;
    end
    if (sel == 11) begin
      // noise line, may hold bare CR or LF
      repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom_range(1, 255)));
      add_str("\r\n");
      return;
    end
    add_junk();
    case (sel)
      0: add_name("st");
      1: add_name("nt");
      2: add_name("nts");
      3: add_name("usn");
      4: add_name("location");
      5, 6, 7: add_name("cache-control");
      default: add_value($urandom_range(1, 10));
    endcase
    add_junk();
    add_str(":");
    add_junk();
    if (sel >= 5 && sel <= 7 && $urandom_range(0, 4) != 0) begin
      add_name("max-age=");
      if ($urandom_range(0, 3) == 0) add_str(" ");
      r = $urandom_range(0, 5);
      if (r == 0) add_str("-");
      else if (r == 1) add_str("+");
      r = $urandom_range(0, 4);
      if (r == 0) add_str("0");
      else repeat ($urandom_range(1, r == 1 ? 14 : 5))
        pkt.push_back(8'($urandom_range("0", "9")));
      if ($urandom_range(0, 3) == 0) add_str(", no-cache");
    end else begin
      r = $urandom_range(0, 19);
      add_value(r == 0 ? $urandom_range(55, 75) : $urandom_range(1, 12));
    end
    add_junk();
    add_str("\r\n");
  endtask

  task automatic random_packet();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (r == 1) begin
      add_start($urandom_range(0, 2));
      pkt[$urandom_range(0, 16)] = 8'($urandom_range(1, 255));
      add_header();
    end else if (r == 2) begin
      add_start($urandom_range(0, 2));
    end else begin
      add_start($urandom_range(0, 2));
      repeat ($urandom_range(1, 5)) add_header();
      if ($urandom_range(0, 1)) add_str("\r\n");
      if ($urandom_range(0, 14) == 0) pkt[$urandom_range(17, pkt.size() - 1)] = 8'h00;
    end
    send_packet();
  endtask

  initial begin
    calm      = 0;
    cfg_valid = 1'b0;
    cfg_data  = 16'd0;
    in_valid  = 1'b0;
    data_byte = 8'd0;
    last_byte = 1'b0;
    idle_cycles = 0;
    sent_bytes  = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every method, every field, number edge cases, bad starts, zero byte
    add_str("M-SEARCH * HTTP/1.1\r\nST: ssdp:all\r\n\r\n"); send_packet();
    add_str("NOTIFY * HTTP/1.1\r\nnt: a\r\nNTS: ssdp:alive\r\nUsn: u\r\nLOCATION: h\r\n");
    send_packet();
    add_str("HTTP/1.1 200 OK\r\nCache-Control: max-age=0\r\n"); send_packet();
    add_str("HTTP/1.1 200 OK\r\nCACHE-CONTROL: max-age= -99999999999\r\n"); send_packet();
    add_str("HTTP/1.1 200 OK\r\ncache-control: max-age=+99999999999x\r\n"); send_packet();
    add_str("NOTIFY * HTTP/1.1\r\n"); send_packet();
    add_str("GET / HTTP/1.1\r\nST: x\r\n"); send_packet();
    add_str("M-SEARCH * HTTP/1.1\r\nST: a"); pkt.push_back(8'h00); add_str("b\r\n");
    send_packet();
    pkt.push_back(8'hFF); send_packet();

    write_age(16'd65535);
    add_str("HTTP/1.1 200 OK\r\nCache-Control: max-age=000\r\n"); send_packet();
    // over-long line dropped, next line still parsed
    add_str("NOTIFY * HTTP/1.1\r\nUSN: ");
    repeat (260) add_str("a");
    add_str("\r\nST: after\r\n"); send_packet();

    write_age(16'd0);
    sent_bytes = 0;
    while (sent_bytes < RandBytes / 3) random_packet();
    write_age(16'($urandom_range(1, 65534)));
    while (sent_bytes < 2 * RandBytes / 3) random_packet();
    write_age(16'd10);
    while (sent_bytes < RandBytes) random_packet();

    wait_idle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
